>>> rtl/lidar_sector_obstacle_guard_unit_defines.svh
// assertion helpers used by the checker file
`ifndef LIDAR_SECTOR_OBSTACLE_GUARD_UNIT_DEFINES_SVH
`define LIDAR_SECTOR_OBSTACLE_GUARD_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LSOG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define LSOG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lsog_pkg.sv
package lsog_pkg;

  // one full turn and half a turn in 0.01 degree units
  localparam logic [15:0] TURN_CDEG      = 16'd36000;
  localparam logic [15:0] HALF_TURN_CDEG = 16'd18000;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // reset values of the configuration registers
  localparam logic [15:0] RST_MIN_DIST   = 16'd0;
  localparam logic [15:0] RST_STOP_DIST  = 16'd300;
  localparam logic [15:0] RST_FRONT_CTR  = 16'd0;
  localparam logic [14:0] RST_HALF_WIDTH = 15'd3000;

  typedef enum logic [1:0] {
    REQ_POINT   = 2'd0,
    REQ_END     = 2'd1,
    REQ_TIMEOUT = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DIST     = 2'd0,
    CFG_STOP_DIST    = 2'd1,
    CFG_FRONT_CENTRE = 2'd2,
    CFG_HALF_WIDTH   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] distance_mm;
    logic [15:0] angle_cdeg;
  } in_t;

  typedef struct packed {
    logic       forward_allowed;
    logic       backward_allowed;
    logic [1:0] obstacle_mask;
  } out_t;

  // live configuration, sector centers already reduced below a turn
  typedef struct packed {
    logic [15:0] min_valid_distance;
    logic [15:0] stop_distance;
    logic [15:0] front_heading;
    logic [15:0] rear_heading;
    logic [14:0] sector_span;
  } cfg_t;

  // reduce a 16-bit angle below one turn (a single subtract suffices)
  function automatic logic [15:0] wrap_turn(input logic [15:0] a);
    wrap_turn = (a >= TURN_CDEG) ? (a - TURN_CDEG) : a;
  endfunction

endpackage

>>> rtl/lsog_cfg.sv
module lsog_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [lsog_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsog_pkg::CFG_DATA_W-1:0]    cfg_data,
  output lsog_pkg::cfg_t                     cfg
);
  import lsog_pkg::*;

  logic [15:0] front_red;
  logic [15:0] back_red;

  // centers are reduced once at write time
  always_comb begin
    front_red = wrap_turn(cfg_data);
    back_red  = (front_red >= HALF_TURN_CDEG) ? (front_red - HALF_TURN_CDEG)
                                              : (front_red + HALF_TURN_CDEG);
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_valid_distance <= RST_MIN_DIST;
      cfg.stop_distance      <= RST_STOP_DIST;
      cfg.front_heading      <= RST_FRONT_CTR;
      cfg.rear_heading       <= HALF_TURN_CDEG;
      cfg.sector_span        <= RST_HALF_WIDTH;
    end else if (cfg_valid) begin
      case (cfg_idx_e'(cfg_index))
        CFG_MIN_DIST:     cfg.min_valid_distance <= cfg_data;
        CFG_STOP_DIST:    cfg.stop_distance      <= cfg_data;
        CFG_FRONT_CENTRE: begin
          cfg.front_heading <= front_red;
          cfg.rear_heading  <= back_red;
        end
        CFG_HALF_WIDTH:   cfg.sector_span        <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/lsog_sector.sv
module lsog_sector (
  input  logic [15:0] angle,
  input  logic [15:0] center,
  input  logic [14:0] span,
  output logic        hit
);
  import lsog_pkg::*;

  logic [16:0] diff;
  logic [15:0] rel;
  logic [15:0] offset;

  // wrapped absolute offset of angle from center, both below a turn
  always_comb begin
    diff   = {1'b0, angle} - {1'b0, center};
    rel    = diff[16] ? (diff[15:0] + TURN_CDEG) : diff[15:0];
    offset = (rel > HALF_TURN_CDEG) ? (TURN_CDEG - rel) : rel;
    hit    = (offset <= {1'b0, span});
  end

endmodule

>>> rtl/lidar_sector_obstacle_guard_unit.sv
// Lidar sector obstacle guard. Point beats mark the front or back sector when
// their distance lies in [min_valid_distance, stop_distance] and their wrapped
// bearing is within the sector half width of the sector center (front checked
// first, back centered half a turn away). An end-of-scan beat returns the
// permissions and mask and clears the marks; a timeout beat returns both
// directions blocked and clears them; point beats and request code 3 return
// nothing. One beat is accepted every cycle unless the input stalls as below; a
// result passes through the input register, then the result register. Input
// stalls only while an end-of-scan or timeout beat sits in the input register
// and the result register holds a result that is not being taken. Configuration
// writes are taken every cycle and should be made while the block is idle.
module lidar_sector_obstacle_guard_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  lsog_pkg::in_t                      item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output lsog_pkg::out_t                     result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lsog_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsog_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lsog_pkg::*;

  cfg_t  cfg;
  logic  s1_valid;
  in_t   s1;
  logic  front_seen;
  logic  back_seen;
  logic  front_hit;
  logic  back_hit;
  logic  in_range;
  logic  makes_result;
  logic  advance;
  out_t  result_next;

  assign cfg_ready = 1'b1;

  lsog_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register, bearing reduced below a turn on capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1.req_type    <= item.req_type;
      s1.distance_mm <= item.distance_mm;
      s1.angle_cdeg  <= wrap_turn(item.angle_cdeg);
    end
  end

  // sector tests
  lsog_sector u_front (
    .angle  (s1.angle_cdeg),
    .center (cfg.front_heading),
    .span   (cfg.sector_span),
    .hit    (front_hit)
  );

  lsog_sector u_back (
    .angle  (s1.angle_cdeg),
    .center (cfg.rear_heading),
    .span   (cfg.sector_span),
    .hit    (back_hit)
  );

  // flow control: only end and timeout beats need the result register
  always_comb begin
    in_range     = (s1.distance_mm >= cfg.min_valid_distance) &&
                   (s1.distance_mm <= cfg.stop_distance);
    makes_result = (s1.req_type == REQ_END) || (s1.req_type == REQ_TIMEOUT);
    advance      = s1_valid && (!makes_result || !result_valid || result_ready);
    item_ready   = !s1_valid || advance;
  end

  // result payload
  always_comb begin
    if (s1.req_type == REQ_TIMEOUT) begin
      result_next.forward_allowed  = 1'b0;
      result_next.backward_allowed = 1'b0;
      result_next.obstacle_mask    = 2'b11;
    end else begin
      result_next.forward_allowed  = !front_seen;
      result_next.backward_allowed = !back_seen;
      result_next.obstacle_mask    = {back_seen, front_seen};
    end
  end

  // sector marks
  always_ff @(posedge clk) begin
    if (rst) begin
      front_seen <= 1'b0;
      back_seen  <= 1'b0;
    end else if (advance) begin
      case (req_e'(s1.req_type))
        REQ_POINT: begin
          if (in_range && front_hit) begin
            front_seen <= 1'b1;
          end else if (in_range && back_hit) begin
            back_seen <= 1'b1;
          end
        end
        REQ_END, REQ_TIMEOUT: begin
          front_seen <= 1'b0;
          back_seen  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && makes_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && makes_result) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/lsog_checker.sv
`include "lidar_sector_obstacle_guard_unit_defines.svh"

module lsog_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_ready,
  input logic                               result_valid,
  input logic                               result_ready,
  input lsog_pkg::out_t                     result
);
  import lsog_pkg::*;

  logic stalled;
  logic mask_ok;
  logic empty;

  assign stalled = result_valid && !result_ready;
  assign mask_ok = (result.forward_allowed == !result.obstacle_mask[0]) &&
                   (result.backward_allowed == !result.obstacle_mask[1]);
  assign empty   = !result_valid && item_ready;

  // a stalled result beat holds
  `LSOG_ASSERT_NEXT(a_hold, clk, rst, stalled, result_valid && $stable(result), "result moved")

  // permissions agree with the mask
  `LSOG_ASSERT_NOW(a_mask, clk, rst, result_valid, mask_ok, "permissions disagree with mask")

  // nothing pending right after reset
  `LSOG_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), empty, "not empty after reset")

  // with the result register empty the input side never stalls
  `LSOG_ASSERT_NOW(a_no_stall, clk, rst, !result_valid, item_ready, "input stalled needlessly")

endmodule

bind lidar_sector_obstacle_guard_unit lsog_checker u_lsog_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

>>> tb/lidar_sector_obstacle_guard_unit_tb.sv
module lidar_sector_obstacle_guard_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsog_pkg::*;

  // request code the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 4;
  localparam int BEATS_PER_PHASE = 57;
  localparam int PHASES = 8;
  localparam int SHOWN_MISSES = 10;

  typedef enum bit {
    ROW_CFG,
    ROW_BEAT
  } row_kind_e;

  typedef struct {
    row_kind_e kind;
    cfg_idx_e  idx;
    logic [15:0] data;
    in_t       beat;
    bit        typed;
    out_t      want;
  } row_t;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  in_t  item;
  logic result_valid;
  logic result_ready;
  out_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow configuration and sector marks
  logic [15:0] cfg_min = RST_MIN_DIST;
  logic [15:0] cfg_stop = RST_STOP_DIST;
  logic [15:0] cfg_front = RST_FRONT_CTR;
  logic [14:0] cfg_half = RST_HALF_WIDTH;
  bit front_seen = 1'b0;
  bit back_seen = 1'b0;

  out_t permission_q[$];
  row_t script[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  lidar_sector_obstacle_guard_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // smallest wrapped distance between two bearings below a turn
  function automatic int unsigned arc_gap(int unsigned a, int unsigned c);
    int unsigned d;
    d = (a + TURN_CDEG - c) % TURN_CDEG;
    return (d > HALF_TURN_CDEG) ? TURN_CDEG - d : d;
  endfunction

  // update sector marks for one beat, return 1 with the permissions if it reports
  function automatic bit predict_guard(input in_t b, output out_t r);
    int unsigned ang;
    int unsigned fc;
    int unsigned bc;
    bit fb;
    bit bb;
    r = '0;
    ang = 32'(b.angle_cdeg % TURN_CDEG);
    case (b.req_type)
      REQ_POINT: begin
        if (b.distance_mm >= cfg_min && b.distance_mm <= cfg_stop) begin
          fc = 32'(cfg_front % TURN_CDEG);
          bc = (fc + HALF_TURN_CDEG) % TURN_CDEG;
          if (arc_gap(ang, fc) <= cfg_half) begin
            front_seen = 1'b1;
          end else if (arc_gap(ang, bc) <= cfg_half) begin
            back_seen = 1'b1;
          end
        end
        return 1'b0;
      end
      REQ_END: begin
        fb = front_seen;
        bb = back_seen;
      end
      REQ_TIMEOUT: begin
        fb = 1'b1;
        bb = 1'b1;
      end
      default: return 1'b0;
    endcase
    front_seen = 1'b0;
    back_seen = 1'b0;
    r.forward_allowed = !fb;
    r.backward_allowed = !bb;
    r.obstacle_mask = {bb, fb};
    return 1'b1;
  endfunction

  // directed rows
  function automatic void add_cfg(cfg_idx_e idx, logic [15:0] data);
    script.push_back('{ROW_CFG, idx, data, '0, 1'b0, '0});
  endfunction

  function automatic void add_beat(logic [1:0] req, logic [15:0] d, logic [15:0] a);
    script.push_back('{ROW_BEAT, CFG_MIN_DIST, '0, '{req, d, a}, 1'b0, '0});
  endfunction

  function automatic void add_typed(logic [1:0] req, bit fwd, bit bwd, logic [1:0] mask);
    script.push_back('{ROW_BEAT, CFG_MIN_DIST, '0, '{req, 16'hFFFF, 16'hFFFF}, 1'b1,
                       '{fwd, bwd, mask}});
  endfunction

  // random beat, mostly points aimed at distance limits and sector edges
  function automatic in_t pick_beat();
    in_t b;
    int roll;
    int v;
    int fc;
    int bc;
    int centre;
    int off;
    int aim;
    b.distance_mm = 16'($urandom);
    b.angle_cdeg = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 4) begin
      b.req_type = REQ_UNUSED;
    end else if (roll < 18) begin
      b.req_type = REQ_END;
    end else if (roll < 23) begin
      b.req_type = REQ_TIMEOUT;
    end else begin
      b.req_type = REQ_POINT;
      case ($urandom_range(3))
        0: v = $urandom_range(65535);
        1: v = int'(cfg_min) + int'($urandom_range(4)) - 2;
        2: v = int'(cfg_stop) + int'($urandom_range(4)) - 2;
        default: v = (cfg_min <= cfg_stop) ? $urandom_range(cfg_stop, cfg_min)
                                           : $urandom_range(65535);
      endcase
      b.distance_mm = (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : v[15:0];
      fc = int'(cfg_front % TURN_CDEG);
      bc = (fc + HALF_TURN_CDEG) % TURN_CDEG;
      centre = $urandom_range(1) ? fc : bc;
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(1)) begin
          off = int'(cfg_half) + int'($urandom_range(4)) - 2;
          if ($urandom_range(1)) off = -off;
        end else begin
          off = int'($urandom_range(2 * cfg_half)) - int'(cfg_half);
        end
        aim = ((centre + off) % int'(TURN_CDEG) + int'(TURN_CDEG)) % int'(TURN_CDEG);
        // same bearing written beyond a full turn
        if (aim < 29536 && $urandom_range(7) == 0) aim += int'(TURN_CDEG);
        b.angle_cdeg = aim[15:0];
      end
    end
    return b;
  endfunction

  function automatic void log_miss(string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MISSES) $display("%0t: %s", $realtime, msg);
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic offer_beat(input in_t b, input bit typed, input out_t want);
    out_t r;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (predict_guard(b, r)) permission_q.push_back(typed ? want : r);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MIN_DIST:     cfg_min = data;
      CFG_STOP_DIST:    cfg_stop = data;
      CFG_FRONT_CENTRE: cfg_front = data;
      CFG_HALF_WIDTH:   cfg_half = data[14:0];
      default: ;
    endcase
  endtask

  // wait out every pending result, then let trailing point beats leave the pipe
  task automatic settle_block();
    item_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (permission_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver stalls
  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    out_t want;
    if (!rst && result_valid && result_ready) begin
      if (permission_q.size() == 0) begin
        log_miss($sformatf("result with nothing expected: fwd %0b bwd %0b mask %0b",
                           result.forward_allowed, result.backward_allowed,
                           result.obstacle_mask));
      end else begin
        want = permission_q.pop_front();
        if (want.forward_allowed !== result.forward_allowed ||
            want.backward_allowed !== result.backward_allowed ||
            want.obstacle_mask !== result.obstacle_mask) begin
          log_miss($sformatf("expected fwd %0b bwd %0b mask %0b, got fwd %0b bwd %0b mask %0b",
                             want.forward_allowed, want.backward_allowed, want.obstacle_mask,
                             result.forward_allowed, result.backward_allowed,
                             result.obstacle_mask));
        end
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    forever begin
      @(posedge clk);
      if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    in_t b;
    int counted;
    logic [15:0] hw;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;

    // reset values: min 0, stop 300, centre 0, half width 30 degrees
    add_typed(REQ_END, 1'b1, 1'b1, 2'd0);
    add_typed(REQ_TIMEOUT, 1'b0, 1'b0, 2'd3);
    add_beat(REQ_POINT, 16'd0, 16'd0);
    add_typed(REQ_END, 1'b0, 1'b1, 2'd1);
    add_beat(REQ_POINT, 16'd300, 16'd18000);
    add_typed(REQ_END, 1'b1, 1'b0, 2'd2);
    add_beat(REQ_POINT, 16'd301, 16'd0);
    add_typed(REQ_END, 1'b1, 1'b1, 2'd0);
    // sector edges, wrap below zero, bearings beyond a turn
    add_beat(REQ_POINT, 16'd100, 16'd3001);
    add_beat(REQ_POINT, 16'd100, 16'd65535);
    add_beat(REQ_POINT, 16'd299, 16'd33000);
    add_beat(REQ_END, 16'd0, 16'd0);
    add_beat(REQ_POINT, 16'd1, 16'd36000);
    add_beat(REQ_END, 16'hFFFF, 16'hFFFF);
    // unused code leaves the marks alone
    add_beat(REQ_UNUSED, 16'd0, 16'd0);
    add_typed(REQ_END, 1'b1, 1'b1, 2'd0);
    // timeout clears a back mark
    add_beat(REQ_POINT, 16'd5, 16'd21000);
    add_typed(REQ_TIMEOUT, 1'b0, 1'b0, 2'd3);
    add_typed(REQ_END, 1'b1, 1'b1, 2'd0);
    // offset of exactly half a turn
    add_cfg(CFG_HALF_WIDTH, 16'd18000);
    add_beat(REQ_POINT, 16'd10, 16'd18000);
    add_beat(REQ_END, 16'd0, 16'd0);
    add_cfg(CFG_HALF_WIDTH, 16'd17999);
    add_beat(REQ_POINT, 16'd10, 16'd18000);
    add_beat(REQ_END, 16'd0, 16'd0);
    // minimum above stop distance
    add_cfg(CFG_MIN_DIST, 16'd500);
    add_cfg(CFG_STOP_DIST, 16'd400);
    add_beat(REQ_POINT, 16'd450, 16'd0);
    add_typed(REQ_END, 1'b1, 1'b1, 2'd0);
    // register maxima, centre beyond a turn
    add_cfg(CFG_MIN_DIST, 16'hFFFF);
    add_cfg(CFG_STOP_DIST, 16'hFFFF);
    add_cfg(CFG_FRONT_CENTRE, 16'hFFFF);
    add_cfg(CFG_HALF_WIDTH, 16'h7FFF);
    add_beat(REQ_POINT, 16'hFFFF, 16'hFFFF);
    add_beat(REQ_END, 16'd0, 16'd0);
    // zero half width around the last centre
    add_cfg(CFG_MIN_DIST, 16'd0);
    add_cfg(CFG_FRONT_CENTRE, 16'd35999);
    add_cfg(CFG_HALF_WIDTH, 16'd0);
    add_beat(REQ_POINT, 16'd0, 16'd35999);
    add_beat(REQ_POINT, 16'd7, 16'd17999);
    add_beat(REQ_END, 16'd0, 16'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle_block();
        write_reg(script[i].idx, script[i].data);
      end else begin
        offer_beat(script[i].beat, script[i].typed, script[i].want);
      end
    end

    // random phases, each with its own configuration and one of four idle patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      write_reg(CFG_MIN_DIST, ($urandom_range(7) == 0) ? 16'hFFFF :
                ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(2000)));
      write_reg(CFG_STOP_DIST, ($urandom_range(7) == 0) ? 16'd0 :
                ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(20000, 1000)));
      write_reg(CFG_FRONT_CENTRE, ($urandom_range(5) == 0) ? 16'($urandom_range(65535, 36000))
                                                          : 16'($urandom_range(35999)));
      case ($urandom_range(5))
        0: hw = 16'd0;
        1: hw = 16'd18000;
        2: hw = 16'($urandom_range(32767, 18001));
        default: hw = 16'($urandom_range(17999, 1));
      endcase
      // upper data bit is not part of the half width
      if ($urandom_range(3) == 0) hw[15] = 1'b1;
      write_reg(CFG_HALF_WIDTH, hw);
      counted = 0;
      while (counted < BEATS_PER_PHASE) begin
        b = pick_beat();
        offer_beat(b, 1'b0, '0);
        if (b.req_type != REQ_UNUSED) counted++;
      end
    end

    settle_block();
    if (mismatch_count == 0 && permission_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lsog_pkg.sv
rtl/lsog_cfg.sv
rtl/lsog_sector.sv
rtl/lidar_sector_obstacle_guard_unit.sv
rtl/lsog_checker.sv
tb/lidar_sector_obstacle_guard_unit_tb.sv
